@@ rtl/hkrb_pkg.sv @@
// types, constants and codes shared by the keyboard report builder
`default_nettype none
package hkrb_pkg;

  localparam int KEY_SLOTS_DEF      = 6;
  localparam int LAYOUT_ENTRIES_DEF = 128;

  localparam logic [2:0] OP_PRESS_CHAR   = 3'd0;
  localparam logic [2:0] OP_RELEASE_CHAR = 3'd1;
  localparam logic [2:0] OP_PRESS_RAW    = 3'd2;
  localparam logic [2:0] OP_RELEASE_RAW  = 3'd3;
  localparam logic [2:0] OP_RELEASE_ALL  = 3'd4;
  localparam logic [2:0] OP_LOAD_LAYOUT  = 3'd5;

  localparam logic [7:0] MOD_FIRST     = 8'hE0;
  localparam logic [7:0] MOD_END       = 8'hE8;
  localparam logic [7:0] USAGE_END     = 8'hA5;
  localparam logic [7:0] CHAR_RAW_BASE = 8'h88;
  localparam logic [7:0] CHAR_MOD_BASE = 8'h80;
  localparam logic [7:0] MOD_LSHIFT    = 8'h02;
  localparam logic [7:0] MOD_ALTGR     = 8'h40;
  localparam logic [7:0] USAGE_NON_US  = 8'h32;
  localparam logic [7:0] USAGE_ISO     = 8'h64;
  localparam logic [7:0] SHIFT_LEFT    = 8'hE1;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] code;
    logic [6:0] layout_index;
    logic [7:0] layout_entry;
  } cmd_item_t;

  typedef struct packed {
    logic [7:0] modifier_bits;
    logic [7:0] key_slot_0;
    logic [7:0] key_slot_1;
    logic [7:0] key_slot_2;
    logic [7:0] key_slot_3;
    logic [7:0] key_slot_4;
    logic [7:0] key_slot_5;
    logic       report_sent;
    logic       accepted;
    logic       last_of_run;
  } rpt_item_t;

endpackage
`default_nettype wire

@@ rtl/hid_keyboard_report_builder_top.sv @@
// boot keyboard report builder: modifier byte, key slots, layout table, report sequencer
//
// Each command transfer yields one or two report transfers. Load layout, release all and
// undefined opcodes go straight to the report; a raw key press or release of an ordinary
// usage passes the raw step and slot scan first, a character command also the layout lookup,
// and a shift sent as its own key report adds a raw step and report. The command
// time is set by the single slot comparator, which walks the key slots one per cycle, and by
// the registered read of the layout memory. cmd_stall stays high until the last report of a
// command is in the output register; the next command may enter while that report waits.
`default_nettype none
module hid_keyboard_report_builder_top #(
  parameter int KEY_SLOTS      = hkrb_pkg::KEY_SLOTS_DEF,
  parameter int LAYOUT_ENTRIES = hkrb_pkg::LAYOUT_ENTRIES_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cmd_valid,
  output logic                cmd_stall,
  input  hkrb_pkg::cmd_item_t cmd_data,
  output logic                rpt_valid,
  input  wire                 rpt_stall,
  output hkrb_pkg::rpt_item_t rpt_data,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire                 cfg_data
);
  import hkrb_pkg::*;

  localparam int SLOT_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int LAY_AW = $clog2(LAYOUT_ENTRIES);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_LOOKUP = 5'b00010,
    S_RAW    = 5'b00100,
    S_SCAN   = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  state_t state, state_next;

  logic              shift_key;
  logic [7:0]        modifier;
  logic [7:0]        slots [KEY_SLOTS];
  logic [7:0]        key;
  logic              press;
  logic              pend;
  logic [7:0]        pend_key;
  logic              pend_altgr;
  logic [SLOT_W-1:0] scan_idx;
  logic [SLOT_W-1:0] emp_idx;
  logic              emp_found;
  logic              emit_sent;
  logic              emit_acc;

  logic [7:0]        lay_mem [LAYOUT_ENTRIES];
  logic              lay_vld [LAYOUT_ENTRIES];
  logic [7:0]        rd_data;
  logic              rd_vld;
  logic [LAY_AW-1:0] raddr;
  logic [LAY_AW-1:0] waddr;

  logic              cmd_take;
  logic              is_char_op;
  logic              load_op;
  logic              is_mod_key;
  logic              is_usage;
  logic [7:0]        key_bit;
  logic [7:0]        slot_cur;
  logic              hit;
  logic              scan_last;
  logic [7:0]        ent;
  logic [7:0]        k_raw;
  logic [7:0]        k_map;
  logic [7:0]        mod_mask;
  logic              rpt_free;
  logic              rpt_load;
  logic [7:0]        slot_vis [6];
  rpt_item_t         rpt_next;

  assign cmd_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign cmd_take  = (state == S_IDLE) && cmd_valid;

  assign is_char_op = (cmd_data.opcode == OP_PRESS_CHAR) ||
                      (cmd_data.opcode == OP_RELEASE_CHAR);
  assign load_op    = cmd_take && (cmd_data.opcode == OP_LOAD_LAYOUT);
  assign raddr      = LAY_AW'(cmd_data.code[6:0]);
  assign waddr      = LAY_AW'(cmd_data.layout_index);

  assign is_mod_key = (key >= MOD_FIRST) && (key < MOD_END);
  assign is_usage   = (key != 8'h00) && (key < USAGE_END);
  assign key_bit    = 8'h01 << key[2:0];
  assign slot_cur   = slots[scan_idx];
  assign hit        = (slot_cur == key);
  assign scan_last  = (scan_idx == SLOT_W'(KEY_SLOTS - 1));

  assign ent      = rd_vld ? rd_data : 8'h00;
  assign k_raw    = {2'b00, ent[5:0]};
  assign k_map    = (k_raw == USAGE_NON_US) ? USAGE_ISO : k_raw;
  assign mod_mask = ((ent[7] && !shift_key) ? MOD_LSHIFT : 8'h00) |
                    (ent[6] ? MOD_ALTGR : 8'h00);

  assign rpt_free = !rpt_valid || !rpt_stall;
  assign rpt_load = (state == S_EMIT) && rpt_free;

  for (genvar g = 0; g < 6; g++) begin : g_vis
    if (g < KEY_SLOTS) begin : g_on
      assign slot_vis[g] = slots[g];
    end else begin : g_off
      assign slot_vis[g] = 8'h00;
    end
  end

  always_comb begin
    rpt_next.modifier_bits = modifier;
    rpt_next.key_slot_0    = slot_vis[0];
    rpt_next.key_slot_1    = slot_vis[1];
    rpt_next.key_slot_2    = slot_vis[2];
    rpt_next.key_slot_3    = slot_vis[3];
    rpt_next.key_slot_4    = slot_vis[4];
    rpt_next.key_slot_5    = slot_vis[5];
    rpt_next.report_sent   = emit_sent;
    rpt_next.accepted      = emit_acc;
    rpt_next.last_of_run   = !pend;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          if (is_char_op) begin
            state_next = cmd_data.code[7] ? S_RAW : S_LOOKUP;
          end else if ((cmd_data.opcode == OP_PRESS_RAW) ||
                       (cmd_data.opcode == OP_RELEASE_RAW)) begin
            state_next = S_RAW;
          end else begin
            state_next = S_EMIT;
          end
        end
      end
      S_LOOKUP: state_next = (ent == 8'h00) ? S_EMIT : S_RAW;
      S_RAW:    state_next = is_usage ? S_SCAN : S_EMIT;
      S_SCAN:   state_next = (hit || scan_last) ? S_EMIT : S_SCAN;
      S_EMIT: begin
        if (rpt_free) begin
          state_next = pend ? S_RAW : S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // layout memory, registered read
  always_ff @(posedge clk) begin
    if (load_op) begin
      lay_mem[waddr] <= cmd_data.layout_entry;
    end
    rd_data <= lay_mem[raddr];
    rd_vld  <= lay_vld[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      shift_key <= 1'b0;
      modifier  <= 8'h00;
      pend      <= 1'b0;
      rpt_valid <= 1'b0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        slots[i] <= 8'h00;
      end
      for (int i = 0; i < LAYOUT_ENTRIES; i++) begin
        lay_vld[i] <= 1'b0;
      end
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        shift_key <= cfg_data;
      end
      if (load_op) begin
        lay_vld[waddr] <= 1'b1;
      end
      if (rpt_load) begin
        rpt_valid <= 1'b1;
      end else if (!rpt_stall) begin
        rpt_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            press <= (cmd_data.opcode == OP_PRESS_CHAR) ||
                     (cmd_data.opcode == OP_PRESS_RAW);
            pend  <= 1'b0;
            unique case (cmd_data.opcode)
              OP_PRESS_CHAR, OP_RELEASE_CHAR: begin
                if (cmd_data.code >= CHAR_RAW_BASE) begin
                  key <= cmd_data.code - CHAR_RAW_BASE;
                end else if (cmd_data.code >= CHAR_MOD_BASE) begin
                  // modifier character, then a null raw step
                  if (cmd_data.opcode == OP_PRESS_CHAR) begin
                    modifier <= modifier | (8'h01 << cmd_data.code[2:0]);
                  end else begin
                    modifier <= modifier & ~(8'h01 << cmd_data.code[2:0]);
                  end
                  key <= 8'h00;
                end
              end
              OP_PRESS_RAW, OP_RELEASE_RAW: key <= cmd_data.code;
              OP_RELEASE_ALL: begin
                modifier <= 8'h00;
                for (int i = 0; i < KEY_SLOTS; i++) begin
                  slots[i] <= 8'h00;
                end
                emit_sent <= 1'b1;
                emit_acc  <= 1'b1;
              end
              OP_LOAD_LAYOUT: begin
                emit_sent <= 1'b0;
                emit_acc  <= 1'b1;
              end
              default: begin
                emit_sent <= 1'b0;
                emit_acc  <= 1'b0;
              end
            endcase
          end
        end
        S_LOOKUP: begin
          if (ent == 8'h00) begin
            emit_sent <= 1'b0;
            emit_acc  <= 1'b0;
          end else if (ent[7] && shift_key && press) begin
            // left shift key report first, key press follows
            key        <= SHIFT_LEFT;
            pend       <= 1'b1;
            pend_key   <= k_map;
            pend_altgr <= ent[6];
          end else begin
            modifier   <= press ? (modifier | mod_mask) : (modifier & ~mod_mask);
            key        <= k_map;
            pend       <= ent[7] && shift_key;
            pend_key   <= SHIFT_LEFT;
            pend_altgr <= 1'b0;
          end
        end
        S_RAW: begin
          scan_idx  <= '0;
          emp_found <= 1'b0;
          if (is_mod_key) begin
            modifier  <= press ? (modifier | key_bit) : (modifier & ~key_bit);
            emit_sent <= 1'b1;
            emit_acc  <= 1'b1;
          end else if (!is_usage) begin
            emit_sent <= !press || (modifier != 8'h00);
            emit_acc  <= !press || (modifier != 8'h00);
          end
        end
        S_SCAN: begin
          scan_idx <= scan_idx + SLOT_W'(1);
          if (press) begin
            if (hit) begin
              emit_sent <= 1'b0;
              emit_acc  <= 1'b1;
            end else begin
              if ((slot_cur == 8'h00) && !emp_found) begin
                emp_found <= 1'b1;
                emp_idx   <= scan_idx;
              end
              if (scan_last) begin
                if (emp_found) begin
                  slots[emp_idx] <= key;
                  emit_sent      <= 1'b1;
                  emit_acc       <= 1'b1;
                end else if (slot_cur == 8'h00) begin
                  slots[scan_idx] <= key;
                  emit_sent       <= 1'b1;
                  emit_acc        <= 1'b1;
                end else begin
                  emit_sent <= 1'b0;
                  emit_acc  <= 1'b0;
                end
              end
            end
          end else begin
            if (hit) begin
              slots[scan_idx] <= 8'h00;
            end
            emit_sent <= 1'b1;
            emit_acc  <= 1'b1;
          end
        end
        S_EMIT: begin
          if (rpt_free) begin
            rpt_data <= rpt_next;
            if (pend) begin
              key  <= pend_key;
              pend <= 1'b0;
              if (pend_altgr) begin
                modifier <= modifier | MOD_ALTGR;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  a_single_run_done: assert property (@(posedge clk) disable iff (rst)
    (rpt_load && !pend) |=> (state == S_IDLE))
    else $error("sequencer did not return to idle after the final report");

  a_two_runs_need_mode: assert property (@(posedge clk) disable iff (rst)
    (rpt_load && !rpt_next.last_of_run) |-> shift_key)
    else $error("two-report run outside shift key report mode");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (int'(scan_idx) < KEY_SLOTS))
    else $error("slot scan ran past the last slot");

  a_scan_key_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (key != 8'h00) && (key < USAGE_END))
    else $error("slot scan started for a key that is not an ordinary usage");

endmodule
`default_nettype wire
